@@ rtl/core/ata_pkg.sv @@
// Shared constants for the accelerometer tilt angle pipeline.
package ata_pkg;

    // Widths of the internal datapath (fixed by the 32-bit scaled format)
    localparam int SUM_W   = 64;   // scaled sum of squares
    localparam int ROOT_W  = 32;   // integer square root
    localparam int REM_W   = 34;   // square root partial remainder
    localparam int XY_W    = 36;   // CORDIC vector components, signed
    localparam int ANG_W   = 32;   // CORDIC angle accumulator, 2^-28 rad
    localparam int OUT_W   = 15;   // result angle, 8192 counts per radian
    localparam int TAB_LEN = 24;
    localparam int LANES   = 3;

    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 32'sd12868;
    localparam logic signed [ANG_W-1:0] ROUND_HALF  = 32'sd16384;

    // round(atan(2^-i) * 2^28)
    localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

endpackage

@@ rtl/core/accel_tilt_angles.sv @@
// Pipelined tilt angles (pitch, roll, incline) of a three-axis acceleration sample.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  sample  | sample_valid, sample_ready, accel_x/y/z      | in
//  angle   | angle_valid, angle_ready, pitch/roll/incline | out
//
// One item per clock when the result side keeps up.
// Pipeline stages in order: input, square, sum,
// 32 square root steps, the CORDIC steps, output register.
// rst_n clears only the valid bits; data registers are not reset.
// A stall at the output freezes every stage at once, so nothing is lost.
module accel_tilt_angles
    import ata_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
    output logic                           angle_valid,
    input  logic                           angle_ready,
    output logic signed [OUT_W-1:0]        pitch_angle,
    output logic signed [OUT_W-1:0]        roll_angle,
    output logic signed [OUT_W-1:0]        incline_angle
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = 32 - SAMPLE_WIDTH;
    localparam int NC  = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int NSQ = ROOT_W;

    // whole pipeline moves when the output register is free
    logic advance;
    assign advance      = !angle_valid || angle_ready;
    assign sample_ready = advance;

    // ---------------- stage A: magnitude and sign ----------------
    logic         va_reg;
    logic [W-1:0] mag_a_reg [LANES];
    logic         neg_a_reg [LANES];
    logic signed [W-1:0] smp [LANES];

    assign smp[0] = accel_x;
    assign smp[1] = accel_y;
    assign smp[2] = accel_z;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                neg_a_reg[l] <= smp[l][W-1];
                mag_a_reg[l] <= smp[l][W-1] ? W'(-smp[l]) : W'(smp[l]);
            end
        end
    end

    // ---------------- stage B: squares ----------------
    logic           vb_reg;
    logic [2*W-1:0] sq_b_reg  [LANES];
    logic [W-1:0]   mag_b_reg [LANES];
    logic           neg_b_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                sq_b_reg[l]  <= (2*W)'(mag_a_reg[l]) * (2*W)'(mag_a_reg[l]);
                mag_b_reg[l] <= mag_a_reg[l];
                neg_b_reg[l] <= neg_a_reg[l];
            end
        end
    end

    // ---------------- square root pipeline, level 0 loaded from sums ----------------
    logic              vs_reg   [0:NSQ];
    logic [REM_W-1:0]  rem_reg  [0:NSQ][LANES];
    logic [ROOT_W-1:0] root_reg [0:NSQ][LANES];
    logic [SUM_W-1:0]  rest_reg [0:NSQ][LANES];
    logic [W-1:0]      mag_s_reg [0:NSQ][LANES];
    logic              neg_s_reg [0:NSQ][LANES];

    // lane 0 pitch: y,z ; lane 1 roll: x,z ; lane 2 incline: x,y
    logic [2*W-1:0] sum_ab [LANES];
    assign sum_ab[0] = sq_b_reg[1] + sq_b_reg[2];
    assign sum_ab[1] = sq_b_reg[0] + sq_b_reg[2];
    assign sum_ab[2] = sq_b_reg[0] + sq_b_reg[1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l]   <= '0;
                root_reg[0][l]  <= '0;
                rest_reg[0][l]  <= SUM_W'(sum_ab[l]) << (2*F);
                mag_s_reg[0][l] <= mag_b_reg[l];
                neg_s_reg[0][l] <= neg_b_reg[l];
            end
        end
    end

    // one root bit per stage: restoring square root
    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            logic [REM_W-1:0] shifted;
            logic [REM_W-1:0] trial;
            if (advance)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    shifted = {rem_reg[k][l][REM_W-3:0], rest_reg[k][l][SUM_W-1 -: 2]};
                    trial   = {root_reg[k][l], 2'b01};
                    if (shifted >= trial)
                    begin
                        rem_reg[k+1][l]  <= shifted - trial;
                        root_reg[k+1][l] <= {root_reg[k][l][ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k+1][l]  <= shifted;
                        root_reg[k+1][l] <= {root_reg[k][l][ROOT_W-2:0], 1'b0};
                    end
                    rest_reg[k+1][l]  <= rest_reg[k][l] << 2;
                    mag_s_reg[k+1][l] <= mag_s_reg[k][l];
                    neg_s_reg[k+1][l] <= neg_s_reg[k][l];
                end
            end
        end
    end

    // ---------------- CORDIC vectoring pipeline ----------------
    logic                     vc_reg   [1:NC];
    logic signed [XY_W-1:0]   cx_reg   [1:NC][LANES];
    logic signed [XY_W-1:0]   cy_reg   [1:NC][LANES];
    logic signed [ANG_W-1:0]  cz_reg   [1:NC][LANES];
    logic                     zero_reg [1:NC][LANES];
    logic                     neg_c_reg [1:NC][LANES];

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        logic                    v_cur;
        logic signed [XY_W-1:0]  x_cur    [LANES];
        logic signed [XY_W-1:0]  y_cur    [LANES];
        logic signed [ANG_W-1:0] z_cur    [LANES];
        logic                    zero_cur [LANES];
        logic                    neg_cur  [LANES];

        // first step is fed straight from the last root stage
        if (i == 0)
        begin : g_first
            assign v_cur = vs_reg[NSQ];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign x_cur[l]    = XY_W'(root_reg[NSQ][l]);
                assign y_cur[l]    = XY_W'(mag_s_reg[NSQ][l]) << F;
                assign z_cur[l]    = '0;
                assign zero_cur[l] = (root_reg[NSQ][l] == '0) && (mag_s_reg[NSQ][l] == '0);
                assign neg_cur[l]  = neg_s_reg[NSQ][l];
            end
        end
        else
        begin : g_later
            assign v_cur = vc_reg[i];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign x_cur[l]    = cx_reg[i][l];
                assign y_cur[l]    = cy_reg[i][l];
                assign z_cur[l]    = cz_reg[i][l];
                assign zero_cur[l] = zero_reg[i][l];
                assign neg_cur[l]  = neg_c_reg[i][l];
            end
        end

        always_ff @(posedge clk)
        begin
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            if (advance)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    dx = y_cur[l] >>> i;
                    dy = x_cur[l] >>> i;
                    // rotate toward the x axis
                    if (!y_cur[l][XY_W-1] && (y_cur[l] != '0))
                    begin
                        cx_reg[i+1][l] <= x_cur[l] + dx;
                        cy_reg[i+1][l] <= y_cur[l] - dy;
                        cz_reg[i+1][l] <= z_cur[l] + ATAN_TAB[i];
                    end
                    else
                    begin
                        cx_reg[i+1][l] <= x_cur[l] - dx;
                        cy_reg[i+1][l] <= y_cur[l] + dy;
                        cz_reg[i+1][l] <= z_cur[l] - ATAN_TAB[i];
                    end
                    zero_reg[i+1][l]  <= zero_cur[l];
                    neg_c_reg[i+1][l] <= neg_cur[l];
                end
            end
        end

        // valid bit of this step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vc_reg[i+1] <= 1'b0;
            else if (advance)
                vc_reg[i+1] <= v_cur;
        end
    end

    // ---------------- output: round, clamp, sign ----------------
    logic signed [OUT_W-1:0] ang_next [LANES];
    logic signed [OUT_W-1:0] ang_reg  [LANES];

    always_comb
    begin
        logic signed [ANG_W-1:0] rounded;
        logic signed [ANG_W-1:0] clamped;
        for (int l = 0; l < LANES; l++)
        begin
            rounded = (cz_reg[NC][l] + ROUND_HALF) >>> 15;
            if (rounded > ANGLE_LIMIT)
                clamped = ANGLE_LIMIT;
            else if (rounded < -ANGLE_LIMIT)
                clamped = -ANGLE_LIMIT;
            else
                clamped = rounded;
            if (neg_c_reg[NC][l])
                clamped = -clamped;
            ang_next[l] = zero_reg[NC][l] ? '0 : OUT_W'(clamped);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < LANES; l++)
                ang_reg[l] <= ang_next[l];
        end
    end

    // ---------------- valid bits ----------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vs_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg        <= sample_valid;
            vb_reg        <= va_reg;
            vs_reg[0]     <= vb_reg;
            out_valid_reg <= vc_reg[NC];
        end
    end

    for (genvar k = 0; k < NSQ; k++)
    begin : g_vs
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_reg[k+1] <= 1'b0;
            else if (advance)
                vs_reg[k+1] <= vs_reg[k];
        end
    end

    assign angle_valid   = out_valid_reg;
    assign pitch_angle   = ang_reg[0];
    assign roll_angle    = ang_reg[1];
    assign incline_angle = ang_reg[2];

endmodule
